/* sv/agr_pkg.sv */
`default_nettype none

package agr_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int TARGET_BITS    = 24;
	localparam int GAIN_FRAC_BITS = 20;
	localparam int EXT_BITS       = 24;
	localparam int ACC_BITS       = TARGET_BITS + EXT_BITS;
	localparam int ACC_FRAC       = GAIN_FRAC_BITS + EXT_BITS;
	localparam int LEN_BITS       = 24;
	localparam int UNITY_BITS     = 16;
	localparam int THRESH_BITS    = 20;
	localparam int PROD_BITS      = SAMPLE_BITS + TARGET_BITS;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 20;

	localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_UNITY = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_THRESH = 2'd1;

	localparam logic [UNITY_BITS-1:0]  UNITY_RESET  = 16'd2400;
	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 20'd21;

	localparam logic [TARGET_BITS-1:0] TGT_UNITY = TARGET_BITS'(64'd1 << GAIN_FRAC_BITS);
	localparam logic [ACC_BITS-1:0]    ACC_UNITY = ACC_BITS'(64'd1 << ACC_FRAC);
	localparam logic [LEN_BITS-1:0]    LEN_MAX   = {LEN_BITS{1'b1}};
	localparam logic [PROD_BITS-1:0]   ROUND_HALF = PROD_BITS'(64'd1 << (GAIN_FRAC_BITS - 1));

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LEN_MUL,
		ST_LEN_SUM,
		ST_LEN_CHK,
		ST_DIV,
		ST_APPLY,
		ST_MUL,
		ST_OUT
	} agr_state_t;

	typedef struct packed {
		logic load;
		logic diff_load;
		logic len_mul;
		logic len_sum;
		logic snap;
		logic div_start;
		logic step_load;
		logic apply;
		logic mul;
		logic out_load;
	} agr_cmd_t;

	typedef struct packed {
		logic start_need;
		logic len_zero;
		logic div_done;
		logic out_busy;
	} agr_sts_t;

endpackage

`default_nettype wire

/* sv/agr_divider.sv */
`default_nettype none

module agr_divider import agr_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire [ACC_BITS-1:0]  dividend,
	input  wire [LEN_BITS-1:0]  divisor,
	output logic                done,
	output logic [ACC_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(ACC_BITS);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [LEN_BITS:0]   rem_q;
	logic [ACC_BITS-1:0] quo_q;
	logic [LEN_BITS-1:0] div_q;

	logic [LEN_BITS:0]   rem_sh;
	logic                fits;
	logic [LEN_BITS:0]   rem_next;

	// restoring step: one quotient bit per cycle, MSB first
	always_comb begin
		rem_sh   = {rem_q[LEN_BITS-1:0], quo_q[ACC_BITS-1]};
		fits     = rem_sh >= {1'b0, div_q};
		rem_next = fits ? rem_sh - {1'b0, div_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_BITS'(ACC_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[ACC_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* sv/agr_datapath.sv */
`default_nettype none

module agr_datapath import agr_pkg::*; (
	input  wire                             clk,
	input  wire                             arst_n,
	input  agr_cmd_t                        cmd,
	output agr_sts_t                        sts,
	input  wire signed [SAMPLE_BITS-1:0]    in_sample,
	input  wire signed [TARGET_BITS-1:0]    in_target,
	input  wire                             cfg_wr,
	input  wire [CFG_IDX_BITS-1:0]          cfg_idx,
	input  wire [CFG_DATA_BITS-1:0]         cfg_wdata,
	input  wire                             out_ready,
	output logic                            out_valid,
	output logic [SAMPLE_BITS-1:0]          out_sample,
	output logic                            out_ramping
);

	localparam int LMUL_BITS = EXT_BITS + UNITY_BITS;

	// configuration
	logic [UNITY_BITS-1:0]  unity_q;
	logic [THRESH_BITS-1:0] thresh_q;

	// architectural gain state
	logic signed [ACC_BITS-1:0]    cur_q;
	logic signed [ACC_BITS-1:0]    step_q;
	logic signed [TARGET_BITS-1:0] stored_q;
	logic [LEN_BITS-1:0]           left_q;

	// per-sample working registers
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [TARGET_BITS-1:0] target_q;
	logic                          changed_q;
	logic                          ramp_q;
	logic [ACC_BITS-1:0]           d_q;
	logic                          neg_q;
	logic [LMUL_BITS-1:0]          hiu_s1;
	logic [LMUL_BITS-1:0]          lou_s1;
	logic [LEN_BITS-1:0]           len_q;
	logic signed [PROD_BITS-1:0]   prod_s1;
	logic                          pass_s1;
	logic                          zero_s1;

	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_sample_q;
	logic                          out_ramp_q;

	logic signed [ACC_BITS-1:0]    tgt_acc;
	logic signed [ACC_BITS:0]      diff;
	logic [ACC_BITS:0]             diff_mag;
	logic [LMUL_BITS:0]            len_acc;
	logic [LMUL_BITS:0]            len_full;
	logic                          div_done;
	logic [ACC_BITS-1:0]           quo;
	logic signed [TARGET_BITS-1:0] g;
	logic signed [TARGET_BITS:0]   gap_unity;
	logic [TARGET_BITS:0]          gap_unity_mag;
	logic [TARGET_BITS:0]          g_mag;
	logic signed [PROD_BITS-1:0]   rounded;
	logic signed [PROD_BITS-1:0]   scaled;
	logic [SAMPLE_BITS-1:0]        sat;
	logic [PROD_BITS-SAMPLE_BITS:0] top_bits;
	logic [SAMPLE_BITS-1:0]        y;

	always_comb begin
		tgt_acc  = {target_q, {EXT_BITS{1'b0}}};
		diff     = {tgt_acc[ACC_BITS-1], tgt_acc} - {cur_q[ACC_BITS-1], cur_q};
		diff_mag = diff[ACC_BITS] ? -diff : diff;

		len_acc  = (LMUL_BITS+1)'(hiu_s1) + (LMUL_BITS+1)'(lou_s1 >> EXT_BITS);
		len_full = len_acc >> GAIN_FRAC_BITS;

		// gain applied to the sample: floor of the accumulator
		g             = cur_q[ACC_BITS-1:EXT_BITS];
		gap_unity     = {g[TARGET_BITS-1], g} - {1'b0, TGT_UNITY};
		gap_unity_mag = gap_unity[TARGET_BITS] ? -gap_unity : gap_unity;
		g_mag         = g[TARGET_BITS-1] ? -{g[TARGET_BITS-1], g} : {1'b0, g};

		rounded  = prod_s1 + ROUND_HALF;
		scaled   = rounded >>> GAIN_FRAC_BITS;
		top_bits = scaled[PROD_BITS-1:SAMPLE_BITS-1];
		if (!scaled[PROD_BITS-1] && (top_bits != '0)) begin
			sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (scaled[PROD_BITS-1] && (top_bits != '1)) begin
			sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat = scaled[SAMPLE_BITS-1:0];
		end

		if (ramp_q) begin
			y = sat;
		end else if (pass_s1) begin
			y = sample_q;
		end else if (zero_s1) begin
			y = '0;
		end else begin
			y = sat;
		end
	end

	agr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (d_q),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unity_q  <= UNITY_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr) begin
			if (cfg_idx == CFG_RAMP_UNITY) begin
				unity_q <= cfg_wdata[UNITY_BITS-1:0];
			end else if (cfg_idx == CFG_GAIN_THRESH) begin
				thresh_q <= cfg_wdata[THRESH_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= ACC_UNITY;
			step_q   <= '0;
			stored_q <= TGT_UNITY;
			left_q   <= '0;
		end else begin
			if (cmd.load) begin
				stored_q <= in_target;
			end
			if (cmd.snap) begin
				cur_q  <= tgt_acc;
				step_q <= '0;
				left_q <= '0;
			end
			if (cmd.step_load) begin
				step_q <= neg_q ? -quo : quo;
				left_q <= len_q;
			end
			if (cmd.apply && (left_q != '0)) begin
				cur_q  <= cur_q + step_q;
				left_q <= left_q - 1'b1;
			end
			// last ramp sample: land exactly on the target
			if (cmd.mul && ramp_q && (left_q == '0)) begin
				cur_q  <= tgt_acc;
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q  <= in_sample;
			target_q  <= in_target;
			changed_q <= in_target != stored_q;
		end
		if (cmd.diff_load) begin
			d_q   <= diff_mag[ACC_BITS-1:0];
			neg_q <= diff[ACC_BITS];
		end
		if (cmd.len_mul) begin
			hiu_s1 <= LMUL_BITS'(d_q[ACC_BITS-1:EXT_BITS]) * LMUL_BITS'(unity_q);
			lou_s1 <= LMUL_BITS'(d_q[EXT_BITS-1:0]) * LMUL_BITS'(unity_q);
		end
		if (cmd.len_sum) begin
			len_q <= (len_full > (LMUL_BITS+1)'(LEN_MAX)) ? LEN_MAX : len_full[LEN_BITS-1:0];
		end
		if (cmd.apply) begin
			ramp_q <= left_q != '0;
		end
		if (cmd.mul) begin
			prod_s1 <= sample_q * g;
			pass_s1 <= gap_unity_mag < (TARGET_BITS+1)'(thresh_q);
			zero_s1 <= g_mag < (TARGET_BITS+1)'(thresh_q);
		end
		if (cmd.out_load) begin
			out_sample_q <= y;
			out_ramp_q   <= ramp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.start_need = changed_q || ((left_q == '0) && (cur_q != tgt_acc));
		sts.len_zero   = len_q == '0;
		sts.div_done   = div_done;
		sts.out_busy   = out_valid_q && !out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign out_ramping = out_ramp_q;

endmodule

`default_nettype wire

/* sv/agr_controller.sv */
`default_nettype none

module agr_controller import agr_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  wire      in_valid,
	output logic     in_ready,
	input  agr_sts_t sts,
	output agr_cmd_t cmd
);

	agr_state_t state_q;
	agr_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				state_nxt = sts.start_need ? ST_LEN_MUL : ST_APPLY;
			end
			ST_LEN_MUL: state_nxt = ST_LEN_SUM;
			ST_LEN_SUM: state_nxt = ST_LEN_CHK;
			ST_LEN_CHK: begin
				state_nxt = sts.len_zero ? ST_APPLY : ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_nxt = ST_APPLY;
			end
			ST_APPLY: state_nxt = ST_MUL;
			ST_MUL:   state_nxt = ST_OUT;
			ST_OUT: begin
				if (!sts.out_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CHECK:   cmd.diff_load = 1'b1;
			ST_LEN_MUL: cmd.len_mul = 1'b1;
			ST_LEN_SUM: cmd.len_sum = 1'b1;
			ST_LEN_CHK: begin
				cmd.snap      = sts.len_zero;
				cmd.div_start = !sts.len_zero;
			end
			ST_DIV:   cmd.step_load = sts.div_done;
			ST_APPLY: cmd.apply = 1'b1;
			ST_MUL:   cmd.mul = 1'b1;
			ST_OUT:   cmd.out_load = !sts.out_busy;
			default: begin
				in_ready = 1'b0;
				cmd      = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/audio_gain_with_linear_ramp.sv */
`default_nettype none

// Audio gain with linear ramp smoothing. Each input beat carries a signed
// 24-bit sample and the wanted gain (signed Q3.20, 0x100000 is unity); each
// output beat carries the gained, saturated sample and a flag set when a ramp
// gain was used. A sample on a steady gain goes through the check, apply,
// multiply and output states before the next acceptance. When a new target
// arrives, or the gain is off target with no ramp running, the ramp length
// and step are worked out first, the step in the bit-serial divider; a ramp
// of zero length snaps the gain and skips the divider. A result waiting in the
// output register does not block the next acceptance, only the hand-off of
// the following result. Write ramp_unity_samples (index 0) and gain_threshold
// (index 1) only while no sample is in flight; cfg_ready is always high.
module audio_gain_with_linear_ramp import agr_pkg::*; (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire [47:0]              s_axis_tdata,   // sample_in, gain_set
	output logic                    m_axis_tvalid,
	input  wire                     m_axis_tready,
	output logic [23:0]             m_axis_tdata,   // sample_out
	output logic                    m_axis_tuser,   // ramping
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire [CFG_DATA_BITS-1:0] cfg_data
);

	agr_cmd_t cmd;
	agr_sts_t sts;

	assign cfg_ready = 1'b1;

	agr_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	agr_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
		.in_target   (s_axis_tdata[SAMPLE_BITS+TARGET_BITS-1:SAMPLE_BITS]),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_idx     (cfg_index),
		.cfg_wdata   (cfg_data),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_sample  (m_axis_tdata),
		.out_ramping (m_axis_tuser)
	);

endmodule

`default_nettype wire

/* sv/agr_checker.sv */
`default_nettype none

module agr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [23:0] m_axis_tdata,
	input wire        m_axis_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// one sample at a time: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	// a new result only comes out of a sample in flight
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result with no sample in flight");

endmodule

bind audio_gain_with_linear_ramp agr_checker u_agr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
